/* hw/rtl/jacd_pkg.sv */
package jacd_pkg;

	localparam int RAW_W   = 12;
	localparam int VAL_W   = 13;
	localparam int OUT_W   = 10;
	localparam int MODE_W  = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	// Signed width that holds a center plus or minus the deadzone half width.
	localparam int BND_W   = VAL_W + 2;
	// Signed width of a difference of two axis values.
	localparam int DIFF_W  = VAL_W + 1;
	// Magnitude of (value - cal_min) * 1023.
	localparam int NUM_W   = VAL_W + OUT_W;

	localparam int DEADZONE_HALF_DEF = 300;

	localparam int MODE_REV_X  = 0;
	localparam int MODE_REV_Y  = 1;
	localparam int MODE_SINGLE = 2;

	localparam logic [VAL_W-1:0] REVERSE_BASE = 13'd4096;
	localparam logic [VAL_W-1:0] SINGLE_Y     = 13'd2096;
	localparam logic [VAL_W-1:0] LOW_RST      = 13'd4096;
	localparam logic [VAL_W-1:0] HIGH_RST     = 13'd0;
	localparam logic [VAL_W-1:0] CENTER_RST   = 13'd2048;
	localparam logic [VAL_W-1:0] CAL_MIN_RST  = 13'd0;
	localparam logic [VAL_W-1:0] CAL_MAX_RST  = 13'd4095;

	localparam logic [OUT_W-1:0] CENTER_OUT = 10'd512;
	localparam logic [OUT_W-1:0] OUT_MAX    = 10'd1023;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_CENTER_X  = 3'd1,
		REG_CENTER_Y  = 3'd2,
		REG_CAL_MIN_X = 3'd3,
		REG_CAL_MAX_X = 3'd4,
		REG_CAL_MIN_Y = 3'd5,
		REG_CAL_MAX_Y = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] out_x;
		logic [OUT_W-1:0] out_y;
		logic [VAL_W-1:0] seen_min_x;
		logic [VAL_W-1:0] seen_max_x;
		logic [VAL_W-1:0] seen_min_y;
		logic [VAL_W-1:0] seen_max_y;
	} result_t;

endpackage

/* hw/rtl/jacd_div.sv */
module jacd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [jacd_pkg::NUM_W-1:0]    num,
	input  logic [jacd_pkg::VAL_W-1:0]    den,
	output logic                          done,
	output logic [jacd_pkg::OUT_W-1:0]    quo
);

	localparam int CNT_W = $clog2(jacd_pkg::OUT_W + 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [jacd_pkg::NUM_W-1:0]   rem_q;
	logic [jacd_pkg::NUM_W-1:0]   dsh_q;
	logic [jacd_pkg::OUT_W-1:0]   quo_q;
	logic                         ge;

	// The caller guarantees num < den * 2**OUT_W, so OUT_W quotient bits suffice.
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(jacd_pkg::OUT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= jacd_pkg::NUM_W'({den, {(jacd_pkg::OUT_W-1){1'b0}}});
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[jacd_pkg::OUT_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/joystick_axis_calibrate_deadzone_unit.sv */
// Channel   Direction  Handshake                      Payload
// sample    in         sample_valid / sample_stall    jacd_pkg::sample_t (raw_x, raw_y)
// result    out        result_valid / result_stall    jacd_pkg::result_t
// config    in         APB psel/penable/pwrite/pready  paddr[4:2] selects the register
//
// The two axes go one after the other through one bit-serial restoring divider.
// An axis ends in S_START when the deadzone, an empty range, a negative quotient or
// saturation settles it, and in S_DIV when the divider runs its 10 quotient bits.
// A result waits in S_OUT until the output register is free; the next request
// is taken the cycle after the result enters the output register.
// Reset loads the default configuration and the running extremes; a stalled result holds.
module joystick_axis_calibrate_deadzone_unit #(
	parameter int DEADZONE_HALF = jacd_pkg::DEADZONE_HALF_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jacd_pkg::ADDR_W-1:0]   paddr,
	input  logic [jacd_pkg::DATA_W-1:0]   pwdata,
	output logic [jacd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  jacd_pkg::sample_t             sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output jacd_pkg::result_t             result
);

	localparam int VW = jacd_pkg::VAL_W;
	localparam int OW = jacd_pkg::OUT_W;
	localparam int BW = jacd_pkg::BND_W;
	localparam int DW = jacd_pkg::DIFF_W;
	localparam int NW = jacd_pkg::NUM_W;
	localparam logic signed [BW-1:0] DZ = BW'(DEADZONE_HALF);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_MAG   = 6'b000100,
		S_START = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [jacd_pkg::MODE_W-1:0] mode_q;
	logic [VW-1:0] center_x_q, center_y_q;
	logic [VW-1:0] cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;
	logic [VW-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
	logic [VW-1:0] vx_q, vy_q;
	logic          sel_q;
	logic          dz_q, eq_q, neg_q;
	logic signed [DW-1:0] diff_q, den_q;
	logic [NW-1:0] numabs_q;
	logic [VW-1:0] denabs_q;
	logic [OW-1:0] ox_q, oy_q;
	logic          result_valid_q;
	jacd_pkg::result_t result_q;

	logic          cfg_wr;
	logic          accept;
	logic          out_load;
	logic [VW-1:0] vx, vy;
	logic [VW-1:0] cur_v, cur_c, cur_lo, cur_hi;
	logic signed [BW-1:0] v_s, c_s;
	logic [DW-1:0] diff_abs, den_abs;
	logic          ovf;
	logic          div_start, div_done;
	logic [OW-1:0] div_quo;
	logic          axis_done;
	logic [OW-1:0] axis_res;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			center_x_q  <= jacd_pkg::CENTER_RST;
			center_y_q  <= jacd_pkg::CENTER_RST;
			cal_min_x_q <= jacd_pkg::CAL_MIN_RST;
			cal_max_x_q <= jacd_pkg::CAL_MAX_RST;
			cal_min_y_q <= jacd_pkg::CAL_MIN_RST;
			cal_max_y_q <= jacd_pkg::CAL_MAX_RST;
		end else if (cfg_wr) begin
			case (jacd_pkg::reg_idx_t'(paddr[4:2]))
				jacd_pkg::REG_MODE:      mode_q      <= pwdata[jacd_pkg::MODE_W-1:0];
				jacd_pkg::REG_CENTER_X:  center_x_q  <= pwdata[VW-1:0];
				jacd_pkg::REG_CENTER_Y:  center_y_q  <= pwdata[VW-1:0];
				jacd_pkg::REG_CAL_MIN_X: cal_min_x_q <= pwdata[VW-1:0];
				jacd_pkg::REG_CAL_MAX_X: cal_max_x_q <= pwdata[VW-1:0];
				jacd_pkg::REG_CAL_MIN_Y: cal_min_y_q <= pwdata[VW-1:0];
				jacd_pkg::REG_CAL_MAX_Y: cal_max_y_q <= pwdata[VW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (jacd_pkg::reg_idx_t'(paddr[4:2]))
			jacd_pkg::REG_MODE:      prdata = jacd_pkg::DATA_W'(mode_q);
			jacd_pkg::REG_CENTER_X:  prdata = jacd_pkg::DATA_W'(center_x_q);
			jacd_pkg::REG_CENTER_Y:  prdata = jacd_pkg::DATA_W'(center_y_q);
			jacd_pkg::REG_CAL_MIN_X: prdata = jacd_pkg::DATA_W'(cal_min_x_q);
			jacd_pkg::REG_CAL_MAX_X: prdata = jacd_pkg::DATA_W'(cal_max_x_q);
			jacd_pkg::REG_CAL_MIN_Y: prdata = jacd_pkg::DATA_W'(cal_min_y_q);
			jacd_pkg::REG_CAL_MAX_Y: prdata = jacd_pkg::DATA_W'(cal_max_y_q);
			default:                 prdata = '0;
		endcase
	end

	// Axis values after reversal and single-axis forcing.
	assign vx = mode_q[jacd_pkg::MODE_REV_X] ?
		jacd_pkg::REVERSE_BASE - VW'(sample.raw_x) : VW'(sample.raw_x);
	assign vy = mode_q[jacd_pkg::MODE_SINGLE] ? jacd_pkg::SINGLE_Y :
		mode_q[jacd_pkg::MODE_REV_Y] ?
		jacd_pkg::REVERSE_BASE - VW'(sample.raw_y) : VW'(sample.raw_y);

	assign accept       = sample_valid && (state_q == S_IDLE);
	assign sample_stall = (state_q != S_IDLE);

	// The axis being worked on.
	assign cur_v  = sel_q ? vy_q        : vx_q;
	assign cur_c  = sel_q ? center_y_q  : center_x_q;
	assign cur_lo = sel_q ? cal_min_y_q : cal_min_x_q;
	assign cur_hi = sel_q ? cal_max_y_q : cal_max_x_q;
	assign v_s    = BW'(cur_v);
	assign c_s    = BW'(cur_c);

	assign diff_abs = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
	assign den_abs  = den_q[DW-1]  ? DW'(-den_q)  : DW'(den_q);
	assign ovf      = (numabs_q >= NW'({denabs_q, {OW{1'b0}}}));

	assign div_start = (state_q == S_START) && !dz_q && !eq_q && !neg_q && !ovf;

	jacd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (numabs_q),
		.den    (denabs_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// A negative quotient clamps to zero; a zero numerator gives zero either way.
	always_comb begin
		axis_done = 1'b0;
		axis_res  = '0;
		if (state_q == S_START) begin
			if (dz_q) begin
				axis_done = 1'b1;
				axis_res  = jacd_pkg::CENTER_OUT;
			end else if (eq_q || neg_q) begin
				axis_done = 1'b1;
			end else if (ovf) begin
				axis_done = 1'b1;
				axis_res  = jacd_pkg::OUT_MAX;
			end
		end else if (state_q == S_DIV && div_done) begin
			axis_done = 1'b1;
			axis_res  = div_quo;
		end
	end

	assign out_load = (state_q == S_OUT) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sel_q          <= 1'b0;
			result_valid_q <= 1'b0;
			low_x_q        <= jacd_pkg::LOW_RST;
			high_x_q       <= jacd_pkg::HIGH_RST;
			low_y_q        <= jacd_pkg::LOW_RST;
			high_y_q       <= jacd_pkg::HIGH_RST;
		end else begin
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (vx < low_x_q)  low_x_q  <= vx;
						if (vx > high_x_q) high_x_q <= vx;
						if (vy < low_y_q)  low_y_q  <= vy;
						if (vy > high_y_q) high_y_q <= vy;
						sel_q   <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP:  state_q <= S_MAG;
				S_MAG:   state_q <= S_START;
				S_START, S_DIV: begin
					if (axis_done) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_PREP;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= vx;
			vy_q <= vy;
		end
		if (state_q == S_PREP) begin
			dz_q   <= (v_s > c_s - DZ) && (v_s < c_s + DZ);
			eq_q   <= (cur_lo == cur_hi);
			diff_q <= DW'(cur_v) - DW'(cur_lo);
			den_q  <= DW'(cur_hi) - DW'(cur_lo);
		end
		if (state_q == S_MAG) begin
			// Multiply by 1023 as a shift and one subtract.
			numabs_q <= NW'({diff_abs[VW-1:0], {OW{1'b0}}}) - NW'(diff_abs[VW-1:0]);
			denabs_q <= den_abs[VW-1:0];
			neg_q    <= diff_q[DW-1] ^ den_q[DW-1];
		end
		if (axis_done && !sel_q) begin
			ox_q <= axis_res;
		end
		if (axis_done && sel_q) begin
			oy_q <= axis_res;
		end
		if (out_load) begin
			result_q.out_x      <= ox_q;
			result_q.out_y      <= oy_q;
			result_q.seen_min_x <= low_x_q;
			result_q.seen_max_x <= high_x_q;
			result_q.seen_min_y <= low_y_q;
			result_q.seen_max_y <= high_y_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* hw/rtl/jacd_chk.sv */
module jacd_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  logic              result_valid,
	input  logic              result_stall,
	input  jacd_pkg::result_t result
);

	// A result that waits stays offered.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A waiting result keeps its value.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// One request at a time: after an acceptance the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second request taken right after acceptance");

	// Every result follows at least one request, so the extremes are ordered.
	a_extremes_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.seen_min_x <= result.seen_max_x) &&
			(result.seen_min_y <= result.seen_max_y))
		else $error("running minimum above running maximum");

endmodule

bind joystick_axis_calibrate_deadzone_unit jacd_chk u_jacd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
